@@ design/slid_pkg.sv @@
// shared types and codes for the sorted list block
package slid_pkg;

    typedef logic [1:0] action_t;
    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_DELETE = 2'd1;
    localparam action_t ACT_DUMP   = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE,
        OP_EMPTY
    } op_t;

    typedef struct packed {
        op_t  op;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic dump_last;
    } dp_stat_t;

endpackage

@@ design/slid_in_if.sv @@
// request channel carrying action and value
interface slid_in_if
    import slid_pkg::*;
();
    logic                        valid;
    logic                        ready;
    action_t                     action;
    logic signed [VALUE_W-1:0]   value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

@@ design/slid_out_if.sv @@
// result channel carrying status, entry, count and last flag
interface slid_out_if
    import slid_pkg::*;
();
    logic                        valid;
    logic                        ready;
    status_t                     status;
    logic signed [VALUE_W-1:0]   entry;
    logic [COUNT_W-1:0]          stored_count;
    logic                        last;

    modport source (output valid, status, entry, stored_count, last, input ready);
    modport sink   (input valid, status, entry, stored_count, last, output ready);
endinterface

@@ design/sorted_list_insert_delete.sv @@
// top level of the sorted list block
// Holds up to DEPTH signed 32-bit values in ascending order in a chain of
// registers, duplicates allowed. Insert and delete requests compare the value
// against every cell at once and shift the chain directly, so each
// gives one result. A dump walks the list by rotating the chain one place
// per cycle while the output register is free and gives one result per
// stored entry (last set on the final one), or a single empty result when
// nothing is held; no new request is taken until its last result has
// been loaded. Results sit in an output register, so a request is taken as
// long as that register is empty or being drained. There is no clearing pass
// after reset. Unused action codes are dropped without a result.
module sorted_list_insert_delete
    import slid_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    slid_in_if.sink     request,
    slid_out_if.source  result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    slid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .action    (request.action),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    slid_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (request.value),
        .cmd          (cmd),
        .stat         (stat),
        .status       (result.status),
        .entry        (result.entry),
        .stored_count (result.stored_count),
        .last         (result.last)
    );

endmodule

@@ design/slid_datapath.sv @@
// sorted cell chain, entry count, dump rotation counter and result register
module slid_datapath
    import slid_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    output status_t                   status,
    output logic signed [VALUE_W-1:0] entry,
    output logic [COUNT_W-1:0]        stored_count,
    output logic                      last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] cells_reg [DEPTH];
    logic signed [VALUE_W-1:0] cells_next [DEPTH];
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             rot_reg;
    logic [CW-1:0]             rot_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic [COUNT_W-1:0]        scount_reg;
    logic                      last_reg;
    logic [DEPTH-1:0]          less;
    logic [DEPTH-1:0]          match;
    logic                      full;
    logic                      found;
    logic [CW+COUNT_W-1:0]     count_ext;

    // per-cell compares against the request value
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            less[i]  = (CW'(i) < count_reg) && (cells_reg[i] < value);
            match[i] = (CW'(i) < count_reg) && (cells_reg[i] == value);
        end
    end

    assign full  = (count_reg == CW'(DEPTH));
    assign found = |match;

    assign stat.count_zero = (count_reg == '0);
    assign stat.dump_last  = ((rot_reg + CW'(1)) == count_reg);

    // next state of the chain and the result fields
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            cells_next[i] = cells_reg[i];
        count_next  = count_reg;
        rot_next    = rot_reg;
        status_next = ST_OK;
        entry_next  = value;
        case (cmd.op)
            OP_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!less[i])
                        begin
                            if (i == 0)
                                cells_next[i] = value;
                            else if (less[(i == 0) ? 0 : i - 1])
                                cells_next[i] = value;
                            else
                                cells_next[i] = cells_reg[(i == 0) ? 0 : i - 1];
                        end
                    end
                    count_next = count_reg + CW'(1);
                end
            end
            OP_DELETE:
            begin
                if (!found)
                    status_next = ST_NOT_FOUND;
                else
                begin
                    // entries at or past the first equal one move down
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        if ((CW'(i) < count_reg) && !less[i])
                            cells_next[i] = cells_reg[i + 1];
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            OP_ROTATE:
            begin
                // emit the head and rotate the held entries by one
                entry_next = cells_reg[0];
                for (int i = 0; i < DEPTH; i++)
                begin
                    if ((CW'(i) + CW'(1)) == count_reg)
                        cells_next[i] = cells_reg[0];
                    else if ((CW'(i) + CW'(1)) < count_reg)
                        cells_next[i] = cells_reg[(i == DEPTH - 1) ? i : i + 1];
                end
                rot_next = stat.dump_last ? '0 : rot_reg + CW'(1);
            end
            OP_EMPTY:
            begin
                status_next = ST_EMPTY;
                entry_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    // cell payload, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            cells_reg[i] <= cells_next[i];
    end

    // result register loads whenever an operation is issued
    always_ff @(posedge clk)
    begin
        if (cmd.op != OP_NONE)
        begin
            status_reg <= status_next;
            entry_reg  <= entry_next;
            scount_reg <= count_ext[COUNT_W-1:0];
            last_reg   <= cmd.last;
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rot_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            rot_reg   <= rot_next;
        end
    end

    assign status       = status_reg;
    assign entry        = entry_reg;
    assign stored_count = scount_reg;
    assign last         = last_reg;

endmodule

@@ design/slid_ctrl.sv @@
// controller: request decode, dump sequencing and result valid
module slid_ctrl
    import slid_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  action_t  action,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;

    // command decode
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (action)
                        ACT_INSERT: cmd.op = OP_INSERT;
                        ACT_DELETE: cmd.op = OP_DELETE;
                        ACT_DUMP:
                        begin
                            if (stat.count_zero)
                                cmd.op = OP_EMPTY;
                            else
                            begin
                                cmd.op   = OP_ROTATE;
                                cmd.last = stat.dump_last;
                                if (!stat.dump_last)
                                    state_next = S_DUMP;
                            end
                        end
                        default: cmd.op = OP_NONE;
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    cmd.op   = OP_ROTATE;
                    cmd.last = stat.dump_last;
                    if (stat.dump_last)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.op != OP_NONE)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ dv/tb_sorted_list_insert_delete.sv @@
`timescale 1ns / 1ps
// testbench for the sorted list block: directed table then random requests against a shadow list
module tb_sorted_list_insert_delete;
    import slid_pkg::*;

    localparam int DEPTH           = 16;
    localparam action_t ACT_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 120;
    localparam int PHASE_LEN       = 40;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AT_RESULT  = 150;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        status_t            status;
        value_t             entry;
        logic [COUNT_W-1:0] stored_count;
        logic               last;
    } list_result_t;

    typedef struct {
        action_t      action;
        value_t       value;
        int           reps;
        bit           typed;
        list_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    slid_in_if  req_if ();
    slid_out_if res_if ();

    sorted_list_insert_delete #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    // shadow copy of the list and the results still owed by the block
    value_t       held_values[$];
    list_result_t expected_results[$];
    list_result_t fresh_results[$];
    stim_row_t    stim_rows[$];

    int error_count     = 0;
    int results_checked = 0;
    int n_insert        = 0;
    int n_delete        = 0;
    int n_dump          = 0;
    int n_full          = 0;
    int n_missing       = 0;
    int n_ignored       = 0;
    bit sender_calm     = 1'b0;
    bit receiver_calm   = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic list_result_t make_result(status_t st, value_t ent, int cnt, logic lst);
        list_result_t r;
        r.status       = st;
        r.entry        = ent;
        r.stored_count = cnt[COUNT_W-1:0];
        r.last         = lst;
        return r;
    endfunction

    // apply one request to the shadow list and collect the results it causes
    function automatic void predict_list_op(action_t act, value_t val);
        int pos;
        fresh_results.delete();
        pos = 0;
        case (act)
            ACT_INSERT:
            begin
                n_insert++;
                if (held_values.size() >= DEPTH)
                begin
                    n_full++;
                    fresh_results.push_back(make_result(ST_FULL, val, held_values.size(), 1'b1));
                end
                else
                begin
                    while (pos < held_values.size() && held_values[pos] < val)
                        pos++;
                    held_values.insert(pos, val);
                    fresh_results.push_back(make_result(ST_OK, val, held_values.size(), 1'b1));
                end
            end
            ACT_DELETE:
            begin
                n_delete++;
                while (pos < held_values.size() && held_values[pos] != val)
                    pos++;
                if (pos >= held_values.size())
                begin
                    n_missing++;
                    fresh_results.push_back(
                        make_result(ST_NOT_FOUND, val, held_values.size(), 1'b1));
                end
                else
                begin
                    held_values.delete(pos);
                    fresh_results.push_back(make_result(ST_OK, val, held_values.size(), 1'b1));
                end
            end
            ACT_DUMP:
            begin
                n_dump++;
                if (held_values.size() == 0)
                    fresh_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                else
                    foreach (held_values[k])
                        fresh_results.push_back(make_result(ST_OK, held_values[k],
                            held_values.size(), k == held_values.size() - 1));
            end
            default:
            begin
                n_ignored++;
            end
        endcase
    endfunction

    function automatic void add_row(action_t act, value_t val, int reps, bit typed,
                                    status_t st, value_t ent, int cnt);
        stim_row_t row;
        row.action = act;
        row.value  = val;
        row.reps   = reps;
        row.typed  = typed;
        row.want   = make_result(st, ent, cnt, 1'b1);
        stim_rows.push_back(row);
    endfunction

    // pick a value: often one already held, else small, extreme or fully random
    function automatic value_t pick_value(int held_bias);
        int sel;
        sel = $urandom_range(99);
        if (held_values.size() != 0 && sel < held_bias)
            return held_values[$urandom_range(held_values.size() - 1)];
        sel = $urandom_range(9);
        if (sel < 4)
            return value_t'(int'($urandom_range(16)) - 8);
        if (sel == 4)
        begin
            case ($urandom_range(3))
                0:       return value_t'(32'h7fff_ffff);
                1:       return value_t'(32'h8000_0000);
                2:       return value_t'(0);
                default: return value_t'(-1);
            endcase
        end
        return value_t'($urandom());
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch in %s, got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // offer one request, predict it once taken
    task automatic issue_request(input action_t act, input value_t val, input bit typed,
                                 input list_result_t want);
        @(negedge clk);
        while (!sender_calm && $urandom_range(99) < 7)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.value  <= val;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predict_list_op(act, val);
        if (typed)
            expected_results.push_back(want);
        else
            foreach (fresh_results[k])
                expected_results.push_back(fresh_results[k]);
    endtask

    // result side: random stalls, one long hold-off, and a calm stretch
    initial
    begin
        bit hold_done;
        int hold_left;
        hold_done    = 1'b0;
        hold_left    = 0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            receiver_calm = results_checked >= 170 && results_checked < 260;
            if (!hold_done && results_checked >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (!receiver_calm && $urandom_range(99) < 7)
                res_if.ready <= 1'b0;
            else
                res_if.ready <= 1'b1;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result entry", res_if.entry, '0);
            else
            begin
                want = expected_results.pop_front();
                if (res_if.status !== want.status)
                    report_mismatch("status", res_if.status, want.status);
                if (res_if.entry !== want.entry)
                    report_mismatch("entry", res_if.entry, want.entry);
                if (res_if.stored_count !== want.stored_count)
                    report_mismatch("stored_count", res_if.stored_count, want.stored_count);
                if (res_if.last !== want.last)
                    report_mismatch("last", res_if.last, want.last);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("[sorted_list_insert_delete] ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        action_t act;
        value_t  val;
        int      counted;
        int      roll;
        int      insert_share;

        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.action = ACT_INSERT;
        req_if.value  = '0;

        // directed table; typed expectations only where obvious
        add_row(ACT_DUMP,   0,                         1, 1, ST_EMPTY,     0, 0);
        add_row(ACT_DELETE, 5,                         1, 1, ST_NOT_FOUND, 5, 0);
        add_row(ACT_INSERT, value_t'(32'h7fff_ffff),   1, 1, ST_OK, value_t'(32'h7fff_ffff), 1);
        add_row(ACT_INSERT, value_t'(32'h8000_0000),   1, 1, ST_OK, value_t'(32'h8000_0000), 2);
        add_row(ACT_INSERT, 0,                         1, 1, ST_OK,        0, 3);
        add_row(ACT_INSERT, -1,                        1, 0, ST_OK,        0, 0);
        add_row(ACT_INSERT, 0,                         1, 0, ST_OK,        0, 0);
        add_row(ACT_UNUSED, -1,                        1, 0, ST_OK,        0, 0);
        add_row(ACT_DUMP,   value_t'(32'h1234_5678),   1, 0, ST_OK,        0, 0);
        add_row(ACT_DELETE, 0,                         1, 0, ST_OK,        0, 0);
        // removing the head, a miss, then the tail
        add_row(ACT_DELETE, value_t'(32'h8000_0000),   1, 0, ST_OK,        0, 0);
        add_row(ACT_DELETE, 12345,                     1, 0, ST_OK,        0, 0);
        add_row(ACT_DELETE, value_t'(32'h7fff_ffff),   1, 0, ST_OK,        0, 0);
        // fill to capacity with duplicates, then overflow
        add_row(ACT_INSERT, value_t'(32'h0000_00aa),  14, 0, ST_OK,        0, 0);
        add_row(ACT_INSERT, 1,                         1, 1, ST_FULL,      1, DEPTH);
        add_row(ACT_INSERT, value_t'(32'h8000_0000),   1, 1, ST_FULL, value_t'(32'h8000_0000),
                DEPTH);
        add_row(ACT_DUMP,   -1,                        1, 0, ST_OK,        0, 0);
        add_row(ACT_DELETE, value_t'(32'h0000_00aa),  14, 0, ST_OK,        0, 0);
        add_row(ACT_DELETE, -1,                        1, 0, ST_OK,        0, 0);
        add_row(ACT_DELETE, 0,                         1, 0, ST_OK,        0, 0);
        add_row(ACT_DELETE, 0,                         1, 1, ST_NOT_FOUND, 0, 0);
        add_row(ACT_DUMP,   0,                         1, 1, ST_EMPTY,     0, 0);
        add_row(ACT_INSERT, value_t'(32'h5555_5555),   1, 0, ST_OK,        0, 0);
        add_row(ACT_INSERT, value_t'(32'haaaa_aaaa),   1, 0, ST_OK,        0, 0);
        add_row(ACT_DUMP,   0,                         1, 0, ST_OK,        0, 0);

        // reset
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[r])
            for (int k = 0; k < stim_rows[r].reps; k++)
                issue_request(stim_rows[r].action, stim_rows[r].value,
                              stim_rows[r].typed, stim_rows[r].want);

        // random part: alternating fill and drain phases
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            sender_calm  = counted >= 60 && counted < 110;
            insert_share = ((counted / PHASE_LEN) % 2 == 0) ? 66 : 18;
            roll = $urandom_range(99);
            if (roll < 4)
            begin
                act = ACT_UNUSED;
                val = value_t'($urandom());
            end
            else if (roll < 16)
            begin
                act = ACT_DUMP;
                val = value_t'($urandom());
            end
            else if (roll < 16 + insert_share)
            begin
                act = ACT_INSERT;
                val = pick_value(20);
            end
            else
            begin
                act = ACT_DELETE;
                val = pick_value(75);
            end
            if (act != ACT_UNUSED)
                counted++;
            issue_request(act, val, 1'b0, '0);
        end
        sender_calm = 1'b0;
        @(negedge clk);
        req_if.valid <= 1'b0;

        // drain
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d inserts (%0d into a full list), %0d deletes (%0d misses), %0d dumps",
                 n_insert, n_full, n_delete, n_missing, n_dump);
        $display("%0d requests with an unused action, %0d results checked, %0d mismatches",
                 n_ignored, results_checked, error_count);
        if (error_count == 0)
            $display("[sorted_list_insert_delete] OK");
        else
            $display("[sorted_list_insert_delete] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
design/slid_pkg.sv
design/slid_in_if.sv
design/slid_out_if.sv
design/slid_datapath.sv
design/slid_ctrl.sv
design/sorted_list_insert_delete.sv
dv/tb_sorted_list_insert_delete.sv
